// ===== rtl/hcg_pkg.sv =====
// package for the huffman code generator: sizes, beat types, sequencer states
`default_nettype none
package hcg_pkg;
	localparam int MAX_SYMBOLS = 32;
	localparam int NODE_COUNT = 2 * MAX_SYMBOLS;
	localparam int SYM_W = 8;
	localparam int WEIGHT_W = 16;
	localparam int CODE_W = 31;
	localparam int LEN_W = 5;
	localparam int IDX_W = $clog2(MAX_SYMBOLS);
	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int SP_W = $clog2(NODE_COUNT + 1);
	localparam int POS_W = IDX_W + 2;
	localparam int DEPTH_W = $clog2(MAX_SYMBOLS) + 1;
	localparam int WT_W = WEIGHT_W + $clog2(MAX_SYMBOLS);
	localparam int LEN_MAX = 31;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [WEIGHT_W-1:0] weight;
		logic last_symbol;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] out_symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0] code_length;
		logic last_code;
	} code_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [DEPTH_W-1:0] depth;
		logic [CODE_W-1:0] code;
	} stk_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT,
		ST_SD_START,
		ST_SD_CUR,
		ST_SD_CURW,
		ST_SD_L,
		ST_SD_LN,
		ST_SD_LW,
		ST_SD_RN,
		ST_SD_RW,
		ST_SD_DEC,
		ST_SD_RET,
		ST_MERGE_CHK,
		ST_EX_TOP,
		ST_EX_LAST,
		ST_EX_NODE,
		ST_SUM_A,
		ST_SUM_B,
		ST_SUM_W,
		ST_UP_CHK,
		ST_UP_PN,
		ST_UP_PW,
		ST_ROOT_RD,
		ST_ROOT_GO,
		ST_POP,
		ST_POP_D,
		ST_NODE_RD,
		ST_EMIT_LD,
		ST_EMIT,
		ST_PUSH_R,
		ST_PUSH_L,
		ST_FINISH
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/huffman_code_generator.sv =====
// huffman code generator top level: loader, heap sequencer and tree walk
//
// item channel (item_valid, item_stall, item): one symbol/weight beat per
// cycle while idle. beats beyond MAX_SYMBOLS are dropped; a beat with
// last_symbol set starts code construction and item_stall stays high until
// every code beat has gone out.
// code channel (code_valid, code_stall, code): one beat per leaf in pre-order,
// last_code set on the final beat. a stalled beat holds until taken.
// construction for n symbols runs heap setup, then bottom-up heapify and
// n-1 merges, each sift-down and sift-up level going through a single read
// port on the heap memory and one on the weight memory. the walk fetches
// the root, then pops each node: an internal node pushes its right and then
// its left child, a leaf emits its code beat. receiver stalls hold the walk,
// and a finish state then reopens the item channel.
// reset clears the sequencer, the entry count, the heap fill and the code valid; the
// memories need no clearing since each entry is written before it is read.
`default_nettype none
module huffman_code_generator
	import hcg_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire item_t item,
	output logic code_valid,
	input wire logic code_stall,
	output code_t code
);
	state_t state_q, state_d;

	logic [SYM_W-1:0] sym_mem [MAX_SYMBOLS];
	logic [WT_W-1:0] wt_mem [NODE_COUNT];
	logic [NODE_W-1:0] chl_mem [NODE_COUNT];
	logic [NODE_W-1:0] chr_mem [NODE_COUNT];
	logic [NODE_W-1:0] heap_mem [MAX_SYMBOLS];
	stk_t stk_mem [NODE_COUNT];

	logic [SYM_W-1:0] sym_rd_q;
	logic [WT_W-1:0] wt_rd_q;
	logic [NODE_W-1:0] chl_rd_q, chr_rd_q, heap_rd_q;
	stk_t stk_rd_q;

	logic [CNT_W-1:0] cnt_q, fill_q, init_q;
	logic [IDX_W-1:0] idx_q, best_q, hi_q, pos_q;
	logic [NODE_W-1:0] cur_node_q, best_node_q, tmp_q, a_q, b_q, next_q;
	logic [WT_W-1:0] cur_w_q, best_w_q;
	logic ret_heapify_q, ext_sel_q;
	logic [SP_W-1:0] sp_q;
	stk_t e_q;
	logic out_valid_q;
	code_t out_q;

	logic heap_we, wt_we, ch_we, stk_we;
	logic [IDX_W-1:0] heap_waddr, heap_raddr;
	logic [NODE_W-1:0] heap_wdata, wt_waddr, wt_raddr;
	logic [WT_W-1:0] wt_wdata;
	logic [SP_W-1:0] stk_raddr;
	stk_t stk_wdata;

	logic [POS_W-1:0] lpos, rpos;
	logic load_ok, leaf;
	logic [DEPTH_W-1:0] child_depth;
	logic [CODE_W-1:0] code_r, code_l;

	assign lpos = {1'b0, idx_q, 1'b1};
	assign rpos = {1'b0, idx_q, 1'b0} + POS_W'(2);
	assign load_ok = cnt_q < CNT_W'(MAX_SYMBOLS);
	assign leaf = e_q.node < NODE_W'(cnt_q);
	assign child_depth = e_q.depth + DEPTH_W'(1);
	assign code_r = (e_q.depth < DEPTH_W'(LEN_MAX)) ? {e_q.code[CODE_W-2:0], 1'b1} : e_q.code;
	assign code_l = (e_q.depth < DEPTH_W'(LEN_MAX)) ? {e_q.code[CODE_W-2:0], 1'b0} : e_q.code;

	assign item_stall = state_q != ST_IDLE;
	assign code_valid = out_valid_q;
	assign code = out_q;

	always_comb begin
		state_d = state_q;
		heap_we = 1'b0;
		heap_waddr = idx_q;
		heap_wdata = cur_node_q;
		heap_raddr = idx_q;
		wt_we = 1'b0;
		wt_waddr = NODE_W'(cnt_q);
		wt_wdata = WT_W'(item.weight);
		wt_raddr = heap_rd_q;
		ch_we = 1'b0;
		stk_we = 1'b0;
		stk_raddr = sp_q - SP_W'(1);
		stk_wdata = '{node: chr_rd_q, depth: child_depth, code: code_r};
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					wt_we = load_ok;
					if (item.last_symbol) state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				heap_we = 1'b1;
				heap_waddr = init_q[IDX_W-1:0];
				heap_wdata = NODE_W'(init_q);
				if (init_q == cnt_q - CNT_W'(1)) begin
					state_d = (cnt_q >= CNT_W'(2)) ? ST_SD_START : ST_MERGE_CHK;
				end
			end
			ST_SD_START: state_d = ST_SD_CUR;
			ST_SD_CUR: state_d = ST_SD_CURW;
			ST_SD_CURW: state_d = ST_SD_L;
			ST_SD_L: begin
				heap_raddr = lpos[IDX_W-1:0];
				state_d = (lpos < POS_W'(fill_q)) ? ST_SD_LN : ST_SD_DEC;
			end
			ST_SD_LN: state_d = ST_SD_LW;
			ST_SD_LW: begin
				heap_raddr = rpos[IDX_W-1:0];
				state_d = (rpos < POS_W'(fill_q)) ? ST_SD_RN : ST_SD_DEC;
			end
			ST_SD_RN: state_d = ST_SD_RW;
			ST_SD_RW: state_d = ST_SD_DEC;
			ST_SD_DEC: begin
				heap_we = 1'b1;
				if (best_q == idx_q) begin
					state_d = ST_SD_RET;
				end else begin
					heap_wdata = best_node_q;
					state_d = ST_SD_L;
				end
			end
			ST_SD_RET: begin
				if (ret_heapify_q) begin
					state_d = (hi_q == '0) ? ST_MERGE_CHK : ST_SD_START;
				end else begin
					state_d = ext_sel_q ? ST_SUM_A : ST_EX_TOP;
				end
			end
			ST_MERGE_CHK: state_d = (fill_q > CNT_W'(1)) ? ST_EX_TOP : ST_ROOT_RD;
			ST_EX_TOP: begin
				heap_raddr = '0;
				state_d = ST_EX_LAST;
			end
			ST_EX_LAST: begin
				heap_raddr = IDX_W'(fill_q - CNT_W'(1));
				state_d = ST_EX_NODE;
			end
			ST_EX_NODE: state_d = ST_SD_CURW;
			ST_SUM_A: begin
				wt_raddr = a_q;
				state_d = ST_SUM_B;
			end
			ST_SUM_B: begin
				wt_raddr = b_q;
				state_d = ST_SUM_W;
			end
			ST_SUM_W: begin
				wt_we = 1'b1;
				wt_waddr = next_q;
				wt_wdata = best_w_q + wt_rd_q;
				ch_we = 1'b1;
				state_d = ST_UP_CHK;
			end
			ST_UP_CHK: begin
				heap_raddr = (pos_q - IDX_W'(1)) >> 1;
				if (pos_q == '0) begin
					heap_we = 1'b1;
					heap_waddr = pos_q;
					heap_wdata = next_q;
					state_d = ST_MERGE_CHK;
				end else begin
					state_d = ST_UP_PN;
				end
			end
			ST_UP_PN: state_d = ST_UP_PW;
			ST_UP_PW: begin
				heap_we = 1'b1;
				heap_waddr = pos_q;
				heap_wdata = (cur_w_q < wt_rd_q) ? tmp_q : next_q;
				state_d = (cur_w_q < wt_rd_q) ? ST_UP_CHK : ST_MERGE_CHK;
			end
			ST_ROOT_RD: begin
				heap_raddr = '0;
				state_d = ST_ROOT_GO;
			end
			ST_ROOT_GO: begin
				stk_we = 1'b1;
				stk_wdata = '{node: heap_rd_q, depth: '0, code: '0};
				state_d = ST_POP;
			end
			ST_POP: state_d = ST_POP_D;
			ST_POP_D: state_d = ST_NODE_RD;
			ST_NODE_RD: state_d = leaf ? ST_EMIT_LD : ST_PUSH_R;
			ST_EMIT_LD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!code_stall) state_d = (sp_q == '0) ? ST_FINISH : ST_POP;
			end
			ST_PUSH_R: begin
				stk_we = sp_q < SP_W'(NODE_COUNT);
				state_d = ST_PUSH_L;
			end
			ST_PUSH_L: begin
				stk_we = sp_q < SP_W'(NODE_COUNT);
				stk_wdata = '{node: chl_rd_q, depth: child_depth, code: code_l};
				state_d = ST_POP;
			end
			ST_FINISH: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid && load_ok) begin
			sym_mem[cnt_q[IDX_W-1:0]] <= item.symbol;
		end
		if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
		if (ch_we) begin
			chl_mem[next_q] <= a_q;
			chr_mem[next_q] <= b_q;
		end
		if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
		if (stk_we) stk_mem[sp_q[NODE_W-1:0]] <= stk_wdata;
		sym_rd_q <= sym_mem[e_q.node[IDX_W-1:0]];
		wt_rd_q <= wt_mem[wt_raddr];
		chl_rd_q <= chl_mem[e_q.node];
		chr_rd_q <= chr_mem[e_q.node];
		heap_rd_q <= heap_mem[heap_raddr];
		stk_rd_q <= stk_mem[stk_raddr[NODE_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid && load_ok) cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_INIT: fill_q <= cnt_q;
				ST_EX_NODE: fill_q <= fill_q - CNT_W'(1);
				ST_SUM_W: fill_q <= fill_q + CNT_W'(1);
				ST_EMIT_LD: out_valid_q <= 1'b1;
				ST_EMIT: begin
					if (!code_stall) out_valid_q <= 1'b0;
				end
				ST_FINISH: begin
					cnt_q <= '0;
					fill_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: init_q <= '0;
			ST_INIT: begin
				init_q <= init_q + CNT_W'(1);
				hi_q <= IDX_W'((cnt_q - CNT_W'(2)) >> 1);
				idx_q <= IDX_W'((cnt_q - CNT_W'(2)) >> 1);
				ret_heapify_q <= 1'b1;
				next_q <= NODE_W'(cnt_q);
				sp_q <= '0;
			end
			ST_SD_CUR: cur_node_q <= heap_rd_q;
			ST_SD_CURW: cur_w_q <= wt_rd_q;
			ST_SD_L: begin
				best_q <= idx_q;
				best_w_q <= cur_w_q;
				best_node_q <= cur_node_q;
			end
			ST_SD_LN, ST_SD_RN, ST_UP_PN: tmp_q <= heap_rd_q;
			ST_SD_LW: begin
				if (wt_rd_q < best_w_q) begin
					best_q <= lpos[IDX_W-1:0];
					best_w_q <= wt_rd_q;
					best_node_q <= tmp_q;
				end
			end
			ST_SD_RW: begin
				if (wt_rd_q < best_w_q) begin
					best_q <= rpos[IDX_W-1:0];
					best_w_q <= wt_rd_q;
					best_node_q <= tmp_q;
				end
			end
			ST_SD_DEC: idx_q <= best_q;
			ST_SD_RET: begin
				if (ret_heapify_q) begin
					hi_q <= hi_q - IDX_W'(1);
					idx_q <= hi_q - IDX_W'(1);
				end else begin
					ext_sel_q <= 1'b1;
				end
			end
			ST_MERGE_CHK: begin
				ret_heapify_q <= 1'b0;
				ext_sel_q <= 1'b0;
			end
			ST_EX_LAST: begin
				if (ext_sel_q) b_q <= heap_rd_q;
				else a_q <= heap_rd_q;
			end
			ST_EX_NODE: begin
				cur_node_q <= heap_rd_q;
				idx_q <= '0;
			end
			ST_SUM_B: best_w_q <= wt_rd_q;
			ST_SUM_W: begin
				cur_w_q <= best_w_q + wt_rd_q;
				pos_q <= IDX_W'(fill_q);
			end
			ST_UP_CHK: begin
				if (pos_q == '0) next_q <= next_q + NODE_W'(1);
			end
			ST_UP_PW: begin
				if (cur_w_q < wt_rd_q) pos_q <= (pos_q - IDX_W'(1)) >> 1;
				else next_q <= next_q + NODE_W'(1);
			end
			ST_ROOT_GO: sp_q <= SP_W'(1);
			ST_POP: sp_q <= sp_q - SP_W'(1);
			ST_POP_D: e_q <= stk_rd_q;
			ST_EMIT_LD: begin
				out_q.out_symbol <= sym_rd_q;
				out_q.code_bits <= e_q.code;
				out_q.code_length <= (e_q.depth > DEPTH_W'(LEN_MAX)) ?
					LEN_W'(LEN_MAX) : LEN_W'(e_q.depth);
				out_q.last_code <= sp_q == '0;
			end
			ST_PUSH_R, ST_PUSH_L: begin
				if (sp_q < SP_W'(NODE_COUNT)) sp_q <= sp_q + SP_W'(1);
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/hcg_checker.sv =====
// port-level checker for the huffman code generator and its bind
`default_nettype none
module hcg_checker
	import hcg_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_stall,
	input wire code_valid,
	input wire logic code_stall,
	input wire code_t code
);
	a_busy_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> item_stall)
		else $error("code beat shown while item channel is open");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> code_valid && $stable(code))
		else $error("stalled code beat changed");

	a_len0_last: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code.code_length == '0 |-> code.last_code && code.code_bits == '0)
		else $error("empty code on a non-final beat");

	a_last_opens: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_stall && code.last_code |=> ##1 !item_stall)
		else $error("item channel not reopened after final code beat");
endmodule

bind huffman_code_generator hcg_checker u_hcg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_stall(item_stall),
	.code_valid(code_valid),
	.code_stall(code_stall),
	.code(code)
);
`default_nettype wire
